// ===== rtl/bpc_pkg.sv =====
// shared types and constants of the button press classifier
package bpc_pkg;

  // configuration bus geometry
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // field widths
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;

  // register indexes
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_WINDOW   = 1'b1;

  // register reset values in ms
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd400;

  // result codes
  typedef enum logic [1:0] {
    EVT_NONE   = 2'd0,
    EVT_SINGLE = 2'd1,
    EVT_DOUBLE = 2'd2
  } evt_e;

  // one button sample
  typedef struct packed {
    logic              pressed;
    logic [TIME_W-1:0] now_ms;
  } bpc_smp_t;

  // configuration registers
  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] double_window;
  } bpc_cfg_t;

endpackage

// ===== rtl/bpc_in_if.sv =====
// request channel carrying one button sample
interface bpc_in_if
  import bpc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              pressed;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output pressed, output now_ms, input ready);
  modport sink (input valid, input pressed, input now_ms, output ready);
endinterface

// ===== rtl/bpc_out_if.sv =====
// request channel carrying one classification result
interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;

  modport source (output valid, output event_res, input ready);
  modport sink (input valid, input event_res, output ready);
endinterface

// ===== rtl/bpc_core.sv =====
// classification state and next-state logic for one sample per cycle while en_i is high
module bpc_core
  import bpc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  bpc_smp_t smp_i,
  input  bpc_cfg_t cfg_i,
  output evt_e     evt_o
);

  logic [TIME_W-1:0] press_time_q, press_time_d;
  logic [TIME_W-1:0] release_time_q, release_time_d;
  logic              pending_q, pending_d;
  logic              prior_q;

  logic [TIME_W-1:0] since_press;
  logic [TIME_W-1:0] since_release;
  logic [TIME_W-1:0] debounce_ext;
  logic [TIME_W-1:0] window_ext;
  logic              rise;
  logic              fall;
  logic              in_window;
  evt_e              evt;

  // elapsed times, modulo 2^32
  assign since_press   = smp_i.now_ms - press_time_q;
  assign since_release = smp_i.now_ms - release_time_q;
  assign debounce_ext  = {{(TIME_W-CFG_W){1'b0}}, cfg_i.debounce_time};
  assign window_ext    = {{(TIME_W-CFG_W){1'b0}}, cfg_i.double_window};
  assign in_window     = since_release <= window_ext;

  assign rise = smp_i.pressed & ~prior_q;
  assign fall = ~smp_i.pressed & prior_q;

  // edge and timeout rules
  always_comb begin
    press_time_d   = press_time_q;
    release_time_d = release_time_q;
    pending_d      = pending_q;
    evt            = EVT_NONE;
    if (rise) begin
      if (since_press > debounce_ext) begin
        press_time_d = smp_i.now_ms;
      end
    end else if (fall) begin
      if (since_press < debounce_ext) begin
        // glitch, nothing changes
      end else if (pending_q && in_window) begin
        evt       = EVT_DOUBLE;
        pending_d = 1'b0;
      end else begin
        pending_d      = 1'b1;
        release_time_d = smp_i.now_ms;
      end
    end else if (!smp_i.pressed && pending_q && !in_window) begin
      evt       = EVT_SINGLE;
      pending_d = 1'b0;
    end
  end

  assign evt_o = evt;

  // state update when the sample moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_time_q   <= '0;
      release_time_q <= '0;
      pending_q      <= 1'b0;
      prior_q        <= 1'b0;
    end else if (en_i) begin
      press_time_q   <= press_time_d;
      release_time_q <= release_time_d;
      pending_q      <= pending_d;
      prior_q        <= smp_i.pressed;
    end
  end

  // any reported event closes the pending single
  a_evt_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (evt != EVT_NONE) |=> !pending_q)
    else $error("pending single survived an event");

  // a single is only reported on a steady released level
  a_single_on_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (evt == EVT_SINGLE) |-> !smp_i.pressed && !prior_q)
    else $error("single reported on an edge or while pressed");

  // a release starting a pending single stamps its time
  a_pending_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && fall && !pending_q && (since_press >= debounce_ext)
    |=> pending_q && (release_time_q == $past(smp_i.now_ms)))
    else $error("pending single not started on release");

  // no state moves without a sample
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(press_time_q) && $stable(pending_q) && $stable(prior_q))
    else $error("state changed without a sample");

endmodule

// ===== rtl/button_press_classifier.sv =====
// top level of the button press classifier with its configuration port
//
// Takes one button sample (level and ms timestamp) per clock and returns one
// result per sample: none, single or double press. Samples enter an input
// register; from there the classifier compares the elapsed times against
// the debounce and double-press registers, updates its state and loads the
// result register when that register is empty or being read. A new sample
// can be taken every cycle while the result register is not stalled.
// A stalled result register holds the input stage, which then holds off
// new samples. Registers: debounce_time at address 0 (reset 30), double_window
// at address 4 (reset 400), both 16 bits; write them only while no sample is
// in flight.
module button_press_classifier
  import bpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bpc_in_if.sink                in_req,
  bpc_out_if.source             out_res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  bpc_cfg_t cfg_q;
  logic     cfg_wr;
  logic     reg_sel;

  bpc_smp_t smp_q;
  logic     smp_valid_q;
  logic     out_valid_q;
  evt_e     out_evt_q;
  evt_e     evt;
  logic     advance;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time <= DEBOUNCE_RST;
      cfg_q.double_window <= WINDOW_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_DEBOUNCE: cfg_q.debounce_time <= pwdata[CFG_W-1:0];
        REG_WINDOW:   cfg_q.double_window <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      REG_DEBOUNCE: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cfg_q.debounce_time};
      REG_WINDOW:   prdata = {{(APB_DATA_W-CFG_W){1'b0}}, cfg_q.double_window};
      default:      prdata = '0;
    endcase
  end

  // pipeline flow control
  assign advance      = smp_valid_q & (~out_valid_q | out_res.ready);
  assign in_req.ready = ~smp_valid_q | advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else if (in_req.ready) begin
      smp_valid_q <= in_req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req.valid && in_req.ready) begin
      smp_q.pressed <= in_req.pressed;
      smp_q.now_ms  <= in_req.now_ms;
    end
  end

  // classifier
  bpc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .smp_i  (smp_q),
    .cfg_i  (cfg_q),
    .evt_o  (evt)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_evt_q <= evt;
    end
  end

  assign out_res.valid     = out_valid_q;
  assign out_res.event_res = out_evt_q;

  // a waiting sample never moves past a stalled result
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_res.ready |-> !advance)
    else $error("result overwritten while stalled");

  // a held sample stays in the input register
  a_smp_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_valid_q && !advance |=> smp_valid_q && $stable(smp_q))
    else $error("held sample lost");

endmodule
